/* design/plg_pkg.sv */
// Shared types, widths and codes of the lookahead goal selector.
package plg_pkg;

  localparam int PLG_MAX_POINTS = 256;
  localparam int COORD_W = 24;
  localparam int LOOK_W = 16;
  localparam int STEP_W = 10;
  localparam int IDX_W = 8;
  localparam int DIFF_W = 26;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W = 50;
  localparam int ROOT_W = 25;
  localparam int REM_W = 28;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    DS_SQRT = 1'b0,
    DS_DIV  = 1'b1
  } ds_op_t;

  typedef struct packed {
    logic              start;
    ds_op_t            op;
    logic [SQ_W-1:0]   num;
    logic [ROOT_W-1:0] den;
  } ds_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] result;
  } ds_rsp_t;

endpackage

/* design/plg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module plg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/plg_divsqrt.sv */
// Iterative unit: integer square root two bits a cycle, or restoring division one bit a cycle.
module plg_divsqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  plg_pkg::ds_req_t req,
  output plg_pkg::ds_rsp_t rsp
);
  import plg_pkg::*;

  logic              busy_r, done_r;
  ds_op_t            op_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] res_r;
  logic [ROOT_W-1:0] den_r;

  logic [REM_W-1:0]  sq_sh, sq_trial, dv_sh;
  logic              sq_ge, dv_ge;

  assign sq_sh    = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
  assign sq_trial = {1'b0, res_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign dv_sh    = {rem_r[REM_W-2:0], rad_r[SQ_W-1]};
  assign dv_ge    = dv_sh >= REM_W'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        rad_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        res_r  <= '0;
        cnt_r  <= (req.op == DS_DIV) ? CNT_W'(SQ_W) : CNT_W'(SQ_W / 2);
      end else if (busy_r) begin
        if (op_r == DS_DIV) begin
          rem_r <= dv_ge ? dv_sh - REM_W'(den_r) : dv_sh;
          rad_r <= {rad_r[SQ_W-2:0], dv_ge};
        end else begin
          rem_r <= sq_ge ? sq_sh - sq_trial : sq_sh;
          res_r <= {res_r[ROOT_W-2:0], sq_ge};
          rad_r <= {rad_r[SQ_W-3:0], 2'b00};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = (op_r == DS_DIV) ? rad_r[ROOT_W-1:0] : res_r;

endmodule

/* design/path_lookahead_goal_selector_unit.sv */
// Sequence: clear and append are taken in the idle state; a query computes the squared
// radius, scans points from the progress index, fetches the segment, takes its root, then
// steps backward (two divisions a step); the result item is registered when the search ends.
// Throughput: one item at a time; in_tready is high only between items, so the rate is
// set by the shared multiplier, the iterative root/divide unit and any pending result.
// Reset (rst_n low, synchronous): path empty, progress 0, lookahead 2304, step 102.
// The path store holds no reset value; only written entries are read.
module path_lookahead_goal_selector_unit #(
  parameter int MAX_POINTS = plg_pkg::PLG_MAX_POINTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x[23:0], pos_y[47:24]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // goal_x[23:0], goal_y[47:24], goal_idx[55:48]
  output logic        out_tuser,  // status[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import plg_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(MAX_POINTS + 1);
  localparam logic CFG_LOOKAHEAD = 1'b0;
  localparam logic CFG_STEP = 1'b1;

  typedef enum logic [20:0] {
    S_IDLE    = 21'h000001,
    S_LIM     = 21'h000002,
    S_LIMST   = 21'h000004,
    S_SC_RD   = 21'h000008,
    S_SC_WT   = 21'h000010,
    S_D_SQX   = 21'h000020,
    S_D_SQY   = 21'h000040,
    S_D_CMP   = 21'h000080,
    S_FR_RD   = 21'h000100,
    S_FR_WT   = 21'h000200,
    S_BK_WT   = 21'h000400,
    S_SG_SQX  = 21'h000800,
    S_SG_SQY  = 21'h001000,
    S_SG_ROOT = 21'h002000,
    S_SG_WAIT = 21'h004000,
    S_SM_MX   = 21'h008000,
    S_SM_DX   = 21'h010000,
    S_SM_DXW  = 21'h020000,
    S_SM_MY   = 21'h040000,
    S_SM_DY   = 21'h080000,
    S_SM_DYW  = 21'h100000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_st_r;

  logic [LW-1:0]             len_r, idx_r;
  logic [AW-1:0]             prog_r, front_r;
  logic [LOOK_W-1:0]         look_r;
  logic [STEP_W-1:0]         step_r;
  logic [31:0]               lim_r;
  logic signed [COORD_W-1:0] px_r, py_r, fx_r, fy_r, gx_r, gy_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r, ex_r, ey_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [SQ_W-1:0]           acc_r;
  logic [ROOT_W-1:0]         seg_r;
  logic [DIFF_W-1:0]         along_r;
  logic                      neg_r, scan_r, empty_r;

  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic [SQ_W-1:0]           sum;
  logic [DIFF_W-1:0]         along_inc;
  logic signed [DIFF_W-1:0]  q_s;
  logic signed [COORD_W-1:0] q_coord;
  logic [PROD_W-1:0]         prod_abs;

  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [2*COORD_W-1:0]      ram_rdata;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  cmd_t                      cmd;

  ds_req_t ds_req;
  ds_rsp_t ds_rsp;

  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_valid_r, out_stat_r;

  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE) && !done_st_r;
  assign cfg_ready = 1'b1;
  assign rd_x      = ram_rdata[COORD_W-1:0];
  assign rd_y      = ram_rdata[2*COORD_W-1:COORD_W];
  assign ram_we    = in_tvalid && in_tready && (cmd == CMD_APPEND) && (len_r < LW'(MAX_POINTS));

  plg_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plg_divsqrt u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

  assign sum       = acc_r + prod_r[SQ_W-1:0];
  assign along_inc = along_r + DIFF_W'(step_r);
  assign q_s       = neg_r ? -$signed({1'b0, ds_rsp.result}) : $signed({1'b0, ds_rsp.result});
  assign q_coord   = COORD_W'(q_s);
  assign prod_abs  = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ram_raddr = idx_r[AW-1:0];
    case (state_r)
      S_LIM: begin
        mul_a = $signed(DIFF_W'(look_r));
        mul_b = $signed(DIFF_W'(look_r));
      end
      S_D_SQX: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      S_D_SQY: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      S_FR_RD: ram_raddr = front_r;
      S_FR_WT: ram_raddr = front_r - 1'b1;
      S_SG_SQX: begin
        mul_a = ex_r;
        mul_b = ex_r;
      end
      S_SG_SQY: begin
        mul_a = ey_r;
        mul_b = ey_r;
      end
      S_SM_MX: begin
        mul_a = ex_r;
        mul_b = $signed(along_r);
      end
      S_SM_MY: begin
        mul_a = ey_r;
        mul_b = $signed(along_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    ds_req.start = 1'b0;
    ds_req.op    = DS_DIV;
    ds_req.num   = prod_abs[SQ_W-1:0] + SQ_W'(seg_r >> 1);
    ds_req.den   = seg_r;
    case (state_r)
      S_SG_ROOT: begin
        ds_req.start = 1'b1;
        ds_req.op    = DS_SQRT;
        ds_req.num   = sum;
      end
      S_SM_DX, S_SM_DY: ds_req.start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_tvalid && in_tready && cmd == CMD_QUERY && len_r != '0) state_nxt = S_LIM;
      S_LIM:     state_nxt = S_LIMST;
      S_LIMST:   state_nxt = S_SC_RD;
      S_SC_RD:   state_nxt = (idx_r >= len_r) ? S_FR_RD : S_SC_WT;
      S_SC_WT:   state_nxt = S_D_SQX;
      S_D_SQX:   state_nxt = S_D_SQY;
      S_D_SQY:   state_nxt = S_D_CMP;
      S_D_CMP: begin
        if (scan_r) begin
          state_nxt = (sum >= SQ_W'(lim_r)) ? S_FR_RD : S_SC_RD;
        end else begin
          state_nxt = (sum <= SQ_W'(lim_r) || along_inc > DIFF_W'(seg_r)) ? S_IDLE : S_SM_MX;
        end
      end
      S_FR_RD:   state_nxt = S_FR_WT;
      S_FR_WT:   state_nxt = (front_r == '0) ? S_IDLE : S_BK_WT;
      S_BK_WT:   state_nxt = S_SG_SQX;
      S_SG_SQX:  state_nxt = S_SG_SQY;
      S_SG_SQY:  state_nxt = S_SG_ROOT;
      S_SG_ROOT: state_nxt = S_SG_WAIT;
      S_SG_WAIT: begin
        if (ds_rsp.done) begin
          state_nxt = (ROOT_W'(step_r) > ds_rsp.result) ? S_IDLE : S_SM_MX;
        end
      end
      S_SM_MX:   state_nxt = S_SM_DX;
      S_SM_DX:   state_nxt = S_SM_DXW;
      S_SM_DXW:  if (ds_rsp.done) state_nxt = S_SM_MY;
      S_SM_MY:   state_nxt = S_SM_DY;
      S_SM_DY:   state_nxt = S_SM_DYW;
      S_SM_DYW:  if (ds_rsp.done) state_nxt = S_D_SQX;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_st_r   <= 1'b0;
      len_r       <= '0;
      prog_r      <= '0;
      look_r      <= LOOK_W'(2304);
      step_r      <= STEP_W'(102);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prod_r  <= mul_a * mul_b;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOOKAHEAD) begin
          look_r <= cfg_data;
        end else if (cfg_index == CFG_STEP) begin
          step_r <= (cfg_data[STEP_W-1:0] == '0) ? STEP_W'(1) : cfg_data[STEP_W-1:0];
        end
      end

      if (done_st_r && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_x_r     <= gx_r;
        out_y_r     <= gy_r;
        out_idx_r   <= IDX_W'(front_r);
        out_stat_r  <= empty_r;
        done_st_r   <= 1'b0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            case (cmd)
              CMD_CLEAR: begin
                len_r  <= '0;
                prog_r <= '0;
              end
              CMD_APPEND: if (ram_we) len_r <= len_r + 1'b1;
              CMD_QUERY: begin
                px_r    <= $signed(in_tdata[COORD_W-1:0]);
                py_r    <= $signed(in_tdata[2*COORD_W-1:COORD_W]);
                idx_r   <= LW'(prog_r);
                scan_r  <= 1'b1;
                empty_r <= (len_r == '0);
                if (len_r == '0) begin
                  gx_r      <= '0;
                  gy_r      <= '0;
                  front_r   <= '0;
                  done_st_r <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_LIMST: lim_r <= prod_r[31:0];
        S_SC_RD: begin
          if (idx_r >= len_r) begin
            front_r <= AW'(len_r - 1'b1);
            prog_r  <= AW'(len_r - 1'b1);
          end
        end
        S_SC_WT: begin
          dx_r <= DIFF_W'(rd_x) - DIFF_W'(px_r);
          dy_r <= DIFF_W'(rd_y) - DIFF_W'(py_r);
        end
        S_D_SQY: acc_r <= prod_r[SQ_W-1:0];
        S_D_CMP: begin
          if (scan_r) begin
            if (sum >= SQ_W'(lim_r)) begin
              front_r <= idx_r[AW-1:0];
              prog_r  <= idx_r[AW-1:0];
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            along_r <= along_inc;
            if (sum <= SQ_W'(lim_r) || along_inc > DIFF_W'(seg_r)) done_st_r <= 1'b1;
          end
        end
        S_FR_WT: begin
          fx_r <= rd_x;
          fy_r <= rd_y;
          gx_r <= rd_x;
          gy_r <= rd_y;
          if (front_r == '0) done_st_r <= 1'b1;
        end
        S_BK_WT: begin
          ex_r   <= DIFF_W'(rd_x) - DIFF_W'(fx_r);
          ey_r   <= DIFF_W'(rd_y) - DIFF_W'(fy_r);
          scan_r <= 1'b0;
        end
        S_SG_SQY: acc_r <= prod_r[SQ_W-1:0];
        S_SG_WAIT: begin
          if (ds_rsp.done) begin
            seg_r   <= ds_rsp.result;
            along_r <= DIFF_W'(step_r);
            if (ROOT_W'(step_r) > ds_rsp.result) done_st_r <= 1'b1;
          end
        end
        S_SM_DX, S_SM_DY: neg_r <= prod_r[PROD_W-1];
        S_SM_DXW: if (ds_rsp.done) gx_r <= fx_r + q_coord;
        S_SM_DYW: begin
          if (ds_rsp.done) begin
            gy_r <= fy_r + q_coord;
            dx_r <= DIFF_W'(gx_r) - DIFF_W'(px_r);
            dy_r <= DIFF_W'(fy_r + q_coord) - DIFF_W'(py_r);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_idx_r, out_y_r, out_x_r};
  assign out_tuser  = out_stat_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ds_rsp.done |-> (state_r == S_SG_WAIT || state_r == S_SM_DXW || state_r == S_SM_DYW))
    else $error("divide/root result outside a wait state");

  a_prog_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (LW'(prog_r) < len_r))
    else $error("progress index beyond path length");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_RD) |-> (len_r != '0))
    else $error("scan started on an empty path");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    done_st_r |-> (state_r == S_IDLE))
    else $error("new work started while a result is pending");

endmodule

/* tb/plg_checker.sv */
// Checker for the lookahead goal selector: mirrors the block and compares every goal item.
`timescale 1ns / 100ps
module plg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x[23:0], pos_y[47:24]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // goal_x[23:0], goal_y[47:24], goal_idx[55:48]
  input  logic        out_tuser,  // status[0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  import plg_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] gx;
    logic [COORD_W-1:0] gy;
    logic [IDX_W-1:0]   idx;
    logic               status;
  } goal_t;

  goal_t       goal_q[$];
  longint      pt_x[PLG_MAX_POINTS];
  longint      pt_y[PLG_MAX_POINTS];
  int unsigned path_len;
  int unsigned progress;
  longint      look_r;
  longint      step_r;

  assign pending = goal_q.size();

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint int_sqrt(longint s);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic goal_t select_goal(longint rx, longint ry);
    goal_t  g;
    longint lim;
    longint fx, fy, bx, by, gx, gy, seg, steps, along;
    int unsigned front;
    g = '0;
    if (path_len == 0) begin
      g.status = 1'b1;
      return g;
    end
    lim = look_r * look_r;
    front = path_len - 1;
    for (int unsigned i = progress; i < path_len; i++) begin
      if (sq_dist(pt_x[i], pt_y[i], rx, ry) >= lim) begin
        front = i;
        break;
      end
    end
    progress = front;
    fx = pt_x[front];
    fy = pt_y[front];
    gx = fx;
    gy = fy;
    if (front > 0) begin
      bx = pt_x[front-1];
      by = pt_y[front-1];
      seg = int_sqrt(sq_dist(bx, by, fx, fy));
      steps = seg / step_r;
      for (longint k = 1; k <= steps; k++) begin
        along = k * step_r;
        gx = fx + round_div((bx - fx) * along, seg);
        gy = fy + round_div((by - fy) * along, seg);
        if (sq_dist(gx, gy, rx, ry) <= lim) break;
      end
    end
    g.gx = gx[COORD_W-1:0];
    g.gy = gy[COORD_W-1:0];
    g.idx = front[IDX_W-1:0];
    return g;
  endfunction

  always @(posedge clk) begin
    goal_t got;
    goal_t exp_g;
    cmd_t  cmd;
    if (!rst_n) begin
      goal_q.delete();
      errors = 0;
      path_len = 0;
      progress = 0;
      look_r = 2304;
      step_r = 102;
    end else begin
      if (out_tvalid && out_tready) begin
        got.gx = out_tdata[23:0];
        got.gy = out_tdata[47:24];
        got.idx = out_tdata[55:48];
        got.status = out_tuser;
        if (goal_q.size() == 0) begin
          $error("unexpected goal item: goal_x %0d goal_y %0d", $signed(got.gx),
                 $signed(got.gy));
          errors++;
        end else begin
          exp_g = goal_q.pop_front();
          if (got.gx !== exp_g.gx) begin
            $error("goal_x expected %0d actual %0d", $signed(exp_g.gx), $signed(got.gx));
            errors++;
          end
          if (got.gy !== exp_g.gy) begin
            $error("goal_y expected %0d actual %0d", $signed(exp_g.gy), $signed(got.gy));
            errors++;
          end
          if (got.idx !== exp_g.idx) begin
            $error("goal_idx expected %0d actual %0d", exp_g.idx, got.idx);
            errors++;
          end
          if (got.status !== exp_g.status) begin
            $error("status expected %0d actual %0d", exp_g.status, got.status);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 1'b0) begin
          look_r = cfg_data;
        end else begin
          step_r = cfg_data[STEP_W-1:0];
          if (step_r == 0) step_r = 1;
        end
      end
      if (in_tvalid && in_tready) begin
        cmd = cmd_t'(in_tuser);
        case (cmd)
          CMD_CLEAR: begin
            path_len = 0;
            progress = 0;
          end
          CMD_APPEND: begin
            if (path_len < PLG_MAX_POINTS) begin
              pt_x[path_len] = longint'($signed(in_tdata[23:0]));
              pt_y[path_len] = longint'($signed(in_tdata[47:24]));
              path_len++;
            end
          end
          CMD_QUERY: begin
            goal_q.insert(goal_q.size(), select_goal(longint'($signed(in_tdata[23:0])),
                                                     longint'($signed(in_tdata[47:24]))));
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top: drives path loads, queries and register writes, and gives the verdict.
`timescale 1ns / 100ps
module tb;
  import plg_pkg::*;

  localparam longint COORD_MAX = 8388607;
  localparam longint COORD_MIN = -8388608;
  localparam int     IDLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // pos_x[23:0], pos_y[47:24]
  logic [1:0]  in_tuser;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;  // goal_x[23:0], goal_y[47:24], goal_idx[55:48]
  logic        out_tuser;  // status[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          item_count;
  int          idle_cycles = 0;
  int          ready_hold = 0;
  bit          quiet;

  path_lookahead_goal_selector_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  plg_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint jitter(longint a);
    return longint'($urandom_range(2 * a)) - a;
  endfunction

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      out_tready = quiet ? 1'b1 : ($urandom_range(2) != 0);
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("path_lookahead_goal_selector_unit regression: fail");
      $finish;
    end
  end

  task automatic send_item(cmd_t cmd, longint x, longint y);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tuser = cmd;
    in_tdata = {y[23:0], x[23:0]};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (cmd != CMD_NONE) item_count++;
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    longint look, step_eff, amp, x, y, rx, ry;
    logic [15:0] step_word;
    int npts, nq;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_CLEAR;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    item_count = 0;
    quiet = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_item(CMD_QUERY, 5, -5);
    send_item(CMD_NONE, COORD_MAX, COORD_MIN);
    send_item(CMD_APPEND, COORD_MIN, COORD_MIN);
    send_item(CMD_QUERY, COORD_MAX, COORD_MAX);
    send_item(CMD_QUERY, COORD_MIN, COORD_MIN);
    send_item(CMD_APPEND, COORD_MIN + 100, COORD_MIN + 50);
    send_item(CMD_QUERY, COORD_MIN, COORD_MIN);
    send_item(CMD_APPEND, COORD_MIN + 105, COORD_MIN + 52);
    send_item(CMD_QUERY, COORD_MIN + 3000, COORD_MIN);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_APPEND, COORD_MAX, COORD_MAX);
    send_item(CMD_APPEND, COORD_MAX - 3000, COORD_MAX);
    send_item(CMD_QUERY, COORD_MAX - 3000, COORD_MAX);
    send_item(CMD_QUERY, COORD_MAX, COORD_MAX);
    send_item(CMD_QUERY, COORD_MAX, COORD_MIN);
    send_item(CMD_QUERY, COORD_MIN, COORD_MAX);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_QUERY, 0, 0);

    while (item_count < 1800) begin
      settle();
      case ($urandom_range(5))
        0: look = 0;
        1: look = 65535;
        default: look = $urandom_range(50, 4000);
      endcase
      case ($urandom_range(5))
        0: step_word = 16'd1;
        1: step_word = 16'd1023;
        2: step_word = 16'h0400;
        default: step_word = 16'($urandom_range(1, 1023) | ($urandom_range(63) << 10));
      endcase
      step_eff = step_word[STEP_W-1:0];
      if (step_eff == 0) step_eff = 1;
      if ($urandom_range(1)) begin
        write_reg(1'b0, look[15:0]);
        write_reg(1'b1, step_word);
      end else begin
        write_reg(1'b1, step_word);
        write_reg(1'b0, look[15:0]);
      end
      quiet = ($urandom_range(4) == 0);
      amp = step_eff * 20;
      x = clamp_coord(longint'($signed(24'($urandom))));
      y = clamp_coord(longint'($signed(24'($urandom))));
      send_item(CMD_CLEAR, x, y);
      if ($urandom_range(9) == 0) send_item(CMD_QUERY, x, y);
      npts = ($urandom_range(99) < 90) ? $urandom_range(1, 24) : $urandom_range(250, 262);
      for (int i = 0; i < npts; i++) begin
        x = clamp_coord(x + jitter(amp));
        y = clamp_coord(y + jitter(amp));
        send_item(CMD_APPEND, x, y);
        if ($urandom_range(99) < 20)
          send_item(CMD_QUERY, clamp_coord(x + jitter(look + amp)),
                    clamp_coord(y + jitter(look + amp)));
        if ($urandom_range(99) < 3)
          send_item(CMD_NONE, longint'($signed(24'($urandom))), 0);
      end
      nq = $urandom_range(3, 15);
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(9) == 0) begin
          rx = longint'($signed(24'($urandom)));
          ry = longint'($signed(24'($urandom)));
        end else begin
          rx = clamp_coord(x + jitter(2 * look + 4 * amp));
          ry = clamp_coord(y + jitter(2 * look + 4 * amp));
        end
        send_item(CMD_QUERY, rx, ry);
      end
    end

    quiet = 1'b0;
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (errors == 0)
      $display("path_lookahead_goal_selector_unit regression: pass");
    else
      $display("path_lookahead_goal_selector_unit regression: fail");
    $finish;
  end

endmodule
